>>> rtl/core/eee_pkg.sv
// Shared types, character codes and input modes for the echo escape expander.
// Used by the front end, queue, back end and top level of the core; depends on nothing.
package eee_pkg;

  localparam int unsigned QueueDepthDefault = 4;
  localparam int unsigned MaxBeats = 3;

  localparam logic [1:0] MODE_BYTE = 2'd0;
  localparam logic [1:0] MODE_ARG = 2'd1;
  localparam logic [1:0] MODE_END = 2'd2;

  localparam logic [7:0] CH_BEL = 8'h07;
  localparam logic [7:0] CH_BS = 8'h08;
  localparam logic [7:0] CH_TAB = 8'h09;
  localparam logic [7:0] CH_LF = 8'h0a;
  localparam logic [7:0] CH_VT = 8'h0b;
  localparam logic [7:0] CH_FF = 8'h0c;
  localparam logic [7:0] CH_CR = 8'h0d;
  localparam logic [7:0] CH_ESC = 8'h1b;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_DASH = 8'h2d;
  localparam logic [7:0] CH_ZERO = 8'h30;
  localparam logic [7:0] CH_SEVEN = 8'h37;
  localparam logic [7:0] CH_BSLASH = 8'h5c;
  localparam logic [7:0] CH_LA = 8'h61;
  localparam logic [7:0] CH_LB = 8'h62;
  localparam logic [7:0] CH_LC = 8'h63;
  localparam logic [7:0] CH_LE = 8'h65;
  localparam logic [7:0] CH_LF_LETTER = 8'h66;
  localparam logic [7:0] CH_LN = 8'h6e;
  localparam logic [7:0] CH_LR = 8'h72;
  localparam logic [7:0] CH_LT = 8'h74;
  localparam logic [7:0] CH_LV = 8'h76;

  typedef enum logic [1:0] {
    ESC_NONE = 2'd0,
    ESC_BSLASH = 2'd1,
    ESC_OCTAL = 2'd2
  } esc_phase_t;

  typedef struct packed {
    logic [7:0] ch;
    logic has;
    logic fin;
  } beat_t;

  typedef struct packed {
    logic [1:0] cnt;
    beat_t [MaxBeats-1:0] beats;
  } bundle_t;

  typedef struct packed {
    logic option_phase;
    logic arg_unclassified;
    logic in_option_arg;
    logic printed_any;
    logic no_newline;
    logic escapes_on;
    esc_phase_t escape_phase;
    logic [1:0] octal_digits;
    logic [7:0] octal_accum;
    logic halted;
  } fstate_t;

  localparam fstate_t FSTATE_RESET = '{
    option_phase: 1'b1,
    arg_unclassified: 1'b0,
    in_option_arg: 1'b0,
    printed_any: 1'b0,
    no_newline: 1'b0,
    escapes_on: 1'b0,
    escape_phase: ESC_NONE,
    octal_digits: 2'd0,
    octal_accum: 8'd0,
    halted: 1'b0
  };

endpackage

>>> rtl/core/eee_front.sv
// Front end: accepts input items, tracks option and escape state, and builds
// one bundle of up to three output beats per item. Depends on eee_pkg.
module eee_front (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  input  logic [1:0]          in_mode,
  input  logic [7:0]          in_char_in,
  input  logic                q_full,
  output logic                in_stall,
  output logic                push,
  output eee_pkg::bundle_t    push_bundle
);

  eee_pkg::fstate_t st_r;
  eee_pkg::fstate_t st_nxt;
  eee_pkg::bundle_t bnd;
  logic accept;

  function automatic void emit(inout eee_pkg::bundle_t bd, input logic [7:0] c,
                               input logic h, input logic f);
    if (bd.cnt != 2'd3) begin
      bd.beats[bd.cnt].ch = c;
      bd.beats[bd.cnt].has = h;
      bd.beats[bd.cnt].fin = f;
      bd.cnt = bd.cnt + 2'd1;
    end
  endfunction

  function automatic void clear_escape(inout eee_pkg::fstate_t s);
    s.escape_phase = eee_pkg::ESC_NONE;
    s.octal_digits = 2'd0;
    s.octal_accum = 8'd0;
  endfunction

  function automatic void flush_escape(inout eee_pkg::fstate_t s,
                                       inout eee_pkg::bundle_t bd);
    if (s.escape_phase == eee_pkg::ESC_BSLASH) begin
      emit(bd, eee_pkg::CH_BSLASH, 1'b1, 1'b0);
    end else if (s.escape_phase == eee_pkg::ESC_OCTAL) begin
      emit(bd, s.octal_accum, 1'b1, 1'b0);
    end
    clear_escape(s);
  endfunction

  function automatic void begin_printed(inout eee_pkg::fstate_t s,
                                        inout eee_pkg::bundle_t bd);
    if (s.printed_any) begin
      emit(bd, eee_pkg::CH_SPACE, 1'b1, 1'b0);
    end
    s.printed_any = 1'b1;
  endfunction

  function automatic void plain_byte(inout eee_pkg::fstate_t s,
                                     inout eee_pkg::bundle_t bd, input logic [7:0] b);
    if (s.escapes_on && b == eee_pkg::CH_BSLASH) begin
      s.escape_phase = eee_pkg::ESC_BSLASH;
    end else begin
      emit(bd, b, 1'b1, 1'b0);
    end
  endfunction

  function automatic void printed_byte(inout eee_pkg::fstate_t s,
                                       inout eee_pkg::bundle_t bd, input logic [7:0] b);
    case (s.escape_phase)
      eee_pkg::ESC_BSLASH: begin
        s.escape_phase = eee_pkg::ESC_NONE;
        case (b)
          eee_pkg::CH_LA: emit(bd, eee_pkg::CH_BEL, 1'b1, 1'b0);
          eee_pkg::CH_LB: emit(bd, eee_pkg::CH_BS, 1'b1, 1'b0);
          eee_pkg::CH_LC: s.halted = 1'b1;
          eee_pkg::CH_LE: emit(bd, eee_pkg::CH_ESC, 1'b1, 1'b0);
          eee_pkg::CH_LF_LETTER: emit(bd, eee_pkg::CH_FF, 1'b1, 1'b0);
          eee_pkg::CH_LN: emit(bd, eee_pkg::CH_LF, 1'b1, 1'b0);
          eee_pkg::CH_LR: emit(bd, eee_pkg::CH_CR, 1'b1, 1'b0);
          eee_pkg::CH_LT: emit(bd, eee_pkg::CH_TAB, 1'b1, 1'b0);
          eee_pkg::CH_LV: emit(bd, eee_pkg::CH_VT, 1'b1, 1'b0);
          eee_pkg::CH_BSLASH: emit(bd, eee_pkg::CH_BSLASH, 1'b1, 1'b0);
          eee_pkg::CH_ZERO: begin
            clear_escape(s);
            s.escape_phase = eee_pkg::ESC_OCTAL;
          end
          default: begin
            emit(bd, eee_pkg::CH_BSLASH, 1'b1, 1'b0);
            emit(bd, b, 1'b1, 1'b0);
          end
        endcase
      end
      eee_pkg::ESC_OCTAL: begin
        if (b >= eee_pkg::CH_ZERO && b <= eee_pkg::CH_SEVEN) begin
          s.octal_accum = {s.octal_accum[4:0], 3'b000} + {5'd0, b[2:0]};
          s.octal_digits = s.octal_digits + 2'd1;
          if (s.octal_digits == 2'd3 || s.octal_digits == 2'd0) begin
            emit(bd, s.octal_accum, 1'b1, 1'b0);
            clear_escape(s);
          end
        end else begin
          emit(bd, s.octal_accum, 1'b1, 1'b0);
          clear_escape(s);
          plain_byte(s, bd, b);
        end
      end
      default: begin
        s.escape_phase = eee_pkg::ESC_NONE;
        plain_byte(s, bd, b);
      end
    endcase
  endfunction

  assign in_stall = q_full;
  assign accept = in_valid && !q_full;

  always_comb begin
    st_nxt = st_r;
    bnd = '0;
    case (in_mode)
      eee_pkg::MODE_BYTE: begin
        if (!st_r.halted) begin
          if (st_nxt.option_phase && !st_nxt.in_option_arg) begin
            st_nxt.arg_unclassified = 1'b0;
            if (in_char_in == eee_pkg::CH_DASH) begin
              st_nxt.in_option_arg = 1'b1;
            end else begin
              st_nxt.option_phase = 1'b0;
              begin_printed(st_nxt, bnd);
              printed_byte(st_nxt, bnd, in_char_in);
            end
          end else if (st_nxt.in_option_arg) begin
            if (in_char_in == eee_pkg::CH_LN) st_nxt.no_newline = 1'b1;
            if (in_char_in == eee_pkg::CH_LE) st_nxt.escapes_on = 1'b1;
          end else begin
            printed_byte(st_nxt, bnd, in_char_in);
          end
        end
      end
      eee_pkg::MODE_ARG: begin
        if (!st_r.halted) begin
          flush_escape(st_nxt, bnd);
          if (st_nxt.arg_unclassified) begin
            st_nxt.option_phase = 1'b0;
            begin_printed(st_nxt, bnd);
          end
          st_nxt.arg_unclassified = 1'b0;
          st_nxt.in_option_arg = 1'b0;
          if (st_nxt.option_phase) begin
            st_nxt.arg_unclassified = 1'b1;
          end else begin
            begin_printed(st_nxt, bnd);
          end
        end
      end
      eee_pkg::MODE_END: begin
        if (!st_r.halted) begin
          flush_escape(st_nxt, bnd);
          if (st_nxt.arg_unclassified) begin_printed(st_nxt, bnd);
        end
        if (!st_r.halted && !st_r.no_newline) begin
          emit(bnd, eee_pkg::CH_LF, 1'b1, 1'b1);
        end else begin
          emit(bnd, 8'd0, 1'b0, 1'b1);
        end
        st_nxt = eee_pkg::FSTATE_RESET;
      end
      default: begin
        st_nxt = st_r;
      end
    endcase
  end

  assign push = accept && (bnd.cnt != 2'd0);
  assign push_bundle = bnd;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= eee_pkg::FSTATE_RESET;
    end else if (accept) begin
      st_r <= st_nxt;
    end
  end

endmodule

>>> rtl/core/eee_queue.sv
// Small bundle queue between the front and back ends of the expander.
// Depends on eee_pkg for the bundle type.
module eee_queue #(
  parameter int unsigned Depth = eee_pkg::QueueDepthDefault
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  input  eee_pkg::bundle_t push_bundle,
  input  logic             pop,
  output logic             full,
  output logic             not_empty,
  output eee_pkg::bundle_t head
);

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);
  localparam logic [PtrW-1:0] LastPtr = PtrW'(Depth - 1);
  localparam logic [CntW-1:0] FullCnt = CntW'(Depth);

  eee_pkg::bundle_t mem_r [Depth];
  logic [PtrW-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PtrW-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CntW-1:0] cnt_r, cnt_nxt;
  logic do_push, do_pop;

  assign full = (cnt_r == FullCnt);
  assign not_empty = (cnt_r != '0);
  assign head = mem_r[rd_ptr_r];
  assign do_push = push && !full;
  assign do_pop = pop && not_empty;

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt = cnt_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == LastPtr) ? '0 : wr_ptr_r + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == LastPtr) ? '0 : rd_ptr_r + 1'b1;
    end
    if (do_push && !do_pop) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (do_pop && !do_push) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= push_bundle;
    end
  end

endmodule

>>> rtl/core/eee_back.sv
// Back end: takes bundles from the queue and sends their beats out one per cycle
// while out_stall is low, through a registered output stage. Depends on eee_pkg.
module eee_back (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             q_not_empty,
  input  eee_pkg::bundle_t head,
  output logic             pop,
  input  logic             out_stall,
  output logic             out_valid,
  output logic [7:0]       out_char_out,
  output logic             out_has_byte,
  output logic             out_last
);

  logic [1:0] idx_r, idx_nxt;
  logic out_valid_r, out_valid_nxt;
  eee_pkg::beat_t beat_r;
  logic load;
  logic last_of_bundle;

  assign load = q_not_empty && (!out_valid_r || !out_stall);
  assign last_of_bundle = (idx_r == head.cnt - 2'd1);
  assign pop = load && last_of_bundle;

  always_comb begin
    idx_nxt = idx_r;
    out_valid_nxt = out_valid_r && out_stall;
    if (load) begin
      out_valid_nxt = 1'b1;
      idx_nxt = last_of_bundle ? 2'd0 : idx_r + 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      idx_r <= 2'd0;
      out_valid_r <= 1'b0;
    end else begin
      idx_r <= idx_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      beat_r <= head.beats[idx_r];
    end
  end

  assign out_valid = out_valid_r;
  assign out_char_out = beat_r.ch;
  assign out_has_byte = beat_r.has;
  assign out_last = beat_r.fin;

endmodule

>>> rtl/core/echo_escape_expander_core.sv
// Top level of the echo escape expander: front end, bundle queue, back end.
// Depends on eee_pkg, eee_front, eee_queue and eee_back.
//
//   channel   direction  handshake              payload
//   in_       input      in_valid / in_stall    in_mode, in_char_in
//   out_      output     out_valid / out_stall  out_char_out, out_has_byte, out_last
//
// Each accepted item is classified in its accept cycle and yields zero to three bytes.
// The output register sends one beat per cycle while out_stall is low, taking the
// beats from the bundle queue; the first beat passes through the queue and then the
// output register before it is presented.
// Input is taken whenever the bundle queue has room, independent of output stalls.
// Reset is synchronous and clears all control state.
module echo_escape_expander_core #(
  parameter int unsigned QueueDepth = eee_pkg::QueueDepthDefault
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [1:0] in_mode,
  input  logic [7:0] in_char_in,
  output logic       out_valid,
  input  logic       out_stall,
  output logic [7:0] out_char_out,
  output logic       out_has_byte,
  output logic       out_last
);

  logic push, pop, q_full, q_not_empty;
  eee_pkg::bundle_t push_bundle, head;

  eee_front u_front (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_mode     (in_mode),
    .in_char_in  (in_char_in),
    .q_full      (q_full),
    .in_stall    (in_stall),
    .push        (push),
    .push_bundle (push_bundle)
  );

  eee_queue #(
    .Depth (QueueDepth)
  ) u_queue (
    .clk         (clk),
    .rst_n       (rst_n),
    .push        (push),
    .push_bundle (push_bundle),
    .pop         (pop),
    .full        (q_full),
    .not_empty   (q_not_empty),
    .head        (head)
  );

  eee_back u_back (
    .clk          (clk),
    .rst_n        (rst_n),
    .q_not_empty  (q_not_empty),
    .head         (head),
    .pop          (pop),
    .out_stall    (out_stall),
    .out_valid    (out_valid),
    .out_char_out (out_char_out),
    .out_has_byte (out_has_byte),
    .out_last     (out_last)
  );

endmodule

>>> rtl/core/eee_checker.sv
// Port-level checks for the echo escape expander core, bound to the top level.
// Depends only on the top level's ports.
module eee_checker (
  input logic       clk,
  input logic       rst_n,
  input logic       out_valid,
  input logic       out_stall,
  input logic [7:0] out_char_out,
  input logic       out_has_byte,
  input logic       out_last
);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_char_out)
      && $stable(out_has_byte) && $stable(out_last))
    else $error("Stalled output beat changed.");

  a_bare_is_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_has_byte |-> out_last)
    else $error("Beat without a byte is not the final beat.");

  a_bare_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_has_byte |-> out_char_out == 8'h00)
    else $error("Bare end marker carries a nonzero byte.");

  a_last_newline: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_last && out_has_byte |-> out_char_out == 8'h0a)
    else $error("Final beat with a byte is not a newline.");

endmodule

bind echo_escape_expander_core eee_checker u_eee_checker (
  .clk          (clk),
  .rst_n        (rst_n),
  .out_valid    (out_valid),
  .out_stall    (out_stall),
  .out_char_out (out_char_out),
  .out_has_byte (out_has_byte),
  .out_last     (out_last)
);

>>> bench/echo_escape_expander_core_test.sv
// Self-checking testbench for echo_escape_expander_core: directed and random echo commands.
// Holds its own expansion predictor and beat scoreboard; depends only on eee_pkg and the core.
module echo_escape_expander_core_test;
  timeunit 1ns;
  timeprecision 1ps;

  import eee_pkg::*;

  localparam logic [1:0] MODE_IGNORED = 2'd3;
  localparam int unsigned CycleLimit = 200000;
  localparam int unsigned TailCycles = 20;
  localparam int unsigned LongHold = 150;
  localparam int unsigned RandomItems = 75;
  localparam logic [7:0] ESC_LETTERS [11] = '{CH_LA, CH_LB, CH_LC, CH_LE, CH_LF_LETTER,
    CH_LN, CH_LR, CH_LT, CH_LV, CH_BSLASH, CH_ZERO};

  class echo_beat_board;
    fstate_t fs;
    beat_t owed_beats[$];
    int item_beats;
    int errors;
    int beats_checked;
    int items_taken;
    int commands_done;

    function new();
      fs = FSTATE_RESET;
    endfunction

    task report(string msg);
      errors++;
      if (errors <= 50) $display("ERROR at %0t: %s", $realtime, msg);
    endtask

    function void owe(logic [7:0] c, logic h, logic f);
      beat_t bt;
      if (item_beats >= MaxBeats) return;
      bt.ch = c;
      bt.has = h;
      bt.fin = f;
      owed_beats.push_back(bt);
      item_beats++;
    endfunction

    function void flush_escape();
      if (fs.escape_phase == ESC_BSLASH) owe(CH_BSLASH, 1'b1, 1'b0);
      else if (fs.escape_phase == ESC_OCTAL) owe(fs.octal_accum, 1'b1, 1'b0);
      fs.escape_phase = ESC_NONE;
      fs.octal_digits = 2'd0;
      fs.octal_accum = 8'd0;
    endfunction

    function void open_printed();
      if (fs.printed_any) owe(CH_SPACE, 1'b1, 1'b0);
      fs.printed_any = 1'b1;
    endfunction

    function void plain_byte(logic [7:0] b);
      if (fs.escapes_on && b == CH_BSLASH) fs.escape_phase = ESC_BSLASH;
      else owe(b, 1'b1, 1'b0);
    endfunction

    function void expand_byte(logic [7:0] b);
      if (fs.escape_phase == ESC_BSLASH) begin
        fs.escape_phase = ESC_NONE;
        case (b)
          CH_LA: owe(CH_BEL, 1'b1, 1'b0);
          CH_LB: owe(CH_BS, 1'b1, 1'b0);
          CH_LC: fs.halted = 1'b1;
          CH_LE: owe(CH_ESC, 1'b1, 1'b0);
          CH_LF_LETTER: owe(CH_FF, 1'b1, 1'b0);
          CH_LN: owe(CH_LF, 1'b1, 1'b0);
          CH_LR: owe(CH_CR, 1'b1, 1'b0);
          CH_LT: owe(CH_TAB, 1'b1, 1'b0);
          CH_LV: owe(CH_VT, 1'b1, 1'b0);
          CH_BSLASH: owe(CH_BSLASH, 1'b1, 1'b0);
          CH_ZERO: begin
            fs.escape_phase = ESC_OCTAL;
            fs.octal_digits = 2'd0;
            fs.octal_accum = 8'd0;
          end
          default: begin
            owe(CH_BSLASH, 1'b1, 1'b0);
            owe(b, 1'b1, 1'b0);
          end
        endcase
      end else if (fs.escape_phase == ESC_OCTAL) begin
        if (b >= CH_ZERO && b <= CH_SEVEN) begin
          fs.octal_accum = {fs.octal_accum[4:0], 3'b000} + (b - CH_ZERO);
          fs.octal_digits = fs.octal_digits + 2'd1;
          if (fs.octal_digits == 2'd3) flush_escape();
        end else begin
          flush_escape();
          plain_byte(b);
        end
      end else begin
        plain_byte(b);
      end
    endfunction

    function void take_item(logic [1:0] mode, logic [7:0] b);
      item_beats = 0;
      if (mode != MODE_IGNORED) items_taken++;
      if (mode == MODE_BYTE) begin
        if (fs.halted) return;
        if (fs.option_phase && !fs.in_option_arg) begin
          fs.arg_unclassified = 1'b0;
          if (b == CH_DASH) begin
            fs.in_option_arg = 1'b1;
          end else begin
            fs.option_phase = 1'b0;
            open_printed();
            expand_byte(b);
          end
        end else if (fs.in_option_arg) begin
          if (b == CH_LN) fs.no_newline = 1'b1;
          if (b == CH_LE) fs.escapes_on = 1'b1;
        end else begin
          expand_byte(b);
        end
      end else if (mode == MODE_ARG) begin
        if (fs.halted) return;
        flush_escape();
        if (fs.arg_unclassified) begin
          fs.option_phase = 1'b0;
          open_printed();
        end
        fs.arg_unclassified = 1'b0;
        fs.in_option_arg = 1'b0;
        if (fs.option_phase) fs.arg_unclassified = 1'b1;
        else open_printed();
      end else if (mode == MODE_END) begin
        commands_done++;
        if (!fs.halted) begin
          flush_escape();
          if (fs.arg_unclassified) open_printed();
        end
        if (!fs.halted && !fs.no_newline) owe(CH_LF, 1'b1, 1'b1);
        else owe(8'd0, 1'b0, 1'b1);
        fs = FSTATE_RESET;
      end
    endfunction

    task check_beat(logic [7:0] c, logic h, logic l);
      beat_t bt;
      beats_checked++;
      if (owed_beats.size() == 0) begin
        report($sformatf("unexpected beat char=%02h has=%0b last=%0b", c, h, l));
      end else begin
        bt = owed_beats.pop_front();
        if (c !== bt.ch || h !== bt.has || l !== bt.fin)
          report($sformatf("beat char=%02h has=%0b last=%0b, expected %02h %0b %0b",
                           c, h, l, bt.ch, bt.has, bt.fin));
      end
    endtask
  endclass

  logic clk;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  logic [1:0] in_mode = MODE_BYTE;
  logic [7:0] in_char_in = 8'd0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic [7:0] out_char_out;
  logic out_has_byte;
  logic out_last;

  echo_beat_board board = new();
  bit calm = 1'b0;
  bit hold_req = 1'b0;
  bit hold_done = 1'b0;
  int sent_items = 0;
  int unsigned cycles = 0;

  echo_escape_expander_core u_dut (
    .clk(clk),
    .rst_n(rst_n),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .in_mode(in_mode),
    .in_char_in(in_char_in),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_char_out(out_char_out),
    .out_has_byte(out_has_byte),
    .out_last(out_last)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles >= CycleLimit) begin
      $display("Timeout after %0d cycles with %0d beats outstanding.",
               cycles, board.owed_beats.size());
      $display("Simulation FAILED");
      $finish;
    end
  end

  // Both channels are sampled mid-cycle, where inputs and registered outputs are settled.
  always @(negedge clk) begin
    if (rst_n) begin
      if (out_valid && !out_stall) board.check_beat(out_char_out, out_has_byte, out_last);
      if (in_valid && !in_stall) board.take_item(in_mode, in_char_in);
    end
  end

  initial begin : receiver
    int hold_left;
    hold_left = 0;
    forever begin
      @(posedge clk);
      if (hold_req && !hold_done) begin
        hold_left = LongHold;
        hold_done = 1'b1;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_stall <= 1'b1;
      end else begin
        out_stall <= !calm && ($urandom_range(99) < 27);
      end
    end
  end

  task automatic send_item(logic [1:0] mode, logic [7:0] c);
    bit taken;
    while (!calm && $urandom_range(99) < 27) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_mode <= mode;
    in_char_in <= c;
    do begin
      @(negedge clk);
      taken = !in_stall;
      @(posedge clk);
    end while (!taken);
    if (mode != MODE_IGNORED) sent_items++;
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    while (board.owed_beats.size() != 0) @(posedge clk);
  endtask

  function automatic logic [7:0] text_byte();
    int r;
    r = $urandom_range(99);
    if (r < 25) return CH_BSLASH;
    if (r < 45) return CH_ZERO + 8'($urandom_range(7));
    if (r < 70) return ESC_LETTERS[$urandom_range(10)];
    if (r < 75) return CH_DASH;
    return 8'($urandom_range(255));
  endfunction

  task automatic random_command();
    int n_opts;
    int n_args;
    int len;
    int r;
    r = $urandom_range(99);
    if (r < 12) begin
      // Noise: any mode in any order, often without an argument start.
      len = $urandom_range(3, 8);
      repeat (len) send_item(2'($urandom_range(3)), 8'($urandom_range(255)));
      send_item(MODE_END, 8'($urandom_range(255)));
      return;
    end
    n_opts = $urandom_range(0, 2);
    repeat (n_opts) begin
      send_item(MODE_ARG, 8'($urandom_range(255)));
      send_item(MODE_BYTE, CH_DASH);
      len = $urandom_range(0, 3);
      repeat (len) begin
        r = $urandom_range(99);
        if (r < 50) send_item(MODE_BYTE, CH_LE);
        else if (r < 75) send_item(MODE_BYTE, CH_LN);
        else if (r < 87) send_item(MODE_BYTE, CH_DASH);
        else send_item(MODE_BYTE, 8'($urandom_range(255)));
      end
    end
    n_args = $urandom_range(0, 3);
    repeat (n_args) begin
      send_item(MODE_ARG, 8'($urandom_range(255)));
      len = $urandom_range(0, 6);
      repeat (len) send_item(MODE_BYTE, text_byte());
    end
    if ($urandom_range(9) == 0) send_item(MODE_IGNORED, 8'($urandom_range(255)));
    send_item(MODE_END, 8'($urandom_range(255)));
  endtask

  initial begin : stimulus
    int base;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    send_item(MODE_END, 8'h00);
    send_item(MODE_BYTE, 8'h00);
    send_item(MODE_BYTE, 8'hff);
    send_item(MODE_IGNORED, 8'ha5);
    send_item(MODE_ARG, 8'h00);
    send_item(MODE_END, 8'hff);
    send_item(MODE_ARG, 8'h00);
    send_item(MODE_BYTE, CH_DASH);
    send_item(MODE_BYTE, CH_LN);
    send_item(MODE_BYTE, CH_LE);
    send_item(MODE_ARG, 8'h00);
    send_item(MODE_BYTE, CH_BSLASH);
    send_item(MODE_BYTE, "q");
    send_item(MODE_BYTE, CH_BSLASH);
    send_item(MODE_BYTE, CH_ZERO);
    repeat (3) send_item(MODE_BYTE, CH_SEVEN);
    send_item(MODE_BYTE, CH_BSLASH);
    send_item(MODE_BYTE, CH_ZERO);
    send_item(MODE_BYTE, "8");
    send_item(MODE_BYTE, CH_BSLASH);
    send_item(MODE_ARG, 8'h00);
    send_item(MODE_BYTE, CH_BSLASH);
    send_item(MODE_BYTE, CH_ZERO);
    send_item(MODE_BYTE, "1");
    send_item(MODE_ARG, 8'h00);
    send_item(MODE_BYTE, CH_BSLASH);
    send_item(MODE_BYTE, CH_LC);
    send_item(MODE_BYTE, "z");
    send_item(MODE_ARG, 8'h00);
    send_item(MODE_END, 8'h00);

    base = sent_items;
    while (sent_items < base + RandomItems) begin
      if (sent_items >= base + 15) hold_req = 1'b1;
      calm = (sent_items >= base + 30) && (sent_items < base + 50);
      if (sent_items >= base + 55 && sent_items < base + 62) wait_drained();
      random_command();
    end
    calm = 1'b0;

    wait_drained();
    repeat (TailCycles) @(posedge clk);
    $display("Ran %0d input beats over %0d commands and checked %0d output beats,",
             board.items_taken, board.commands_done, board.beats_checked);
    $display("covering options, every escape, octal wrap, halts and a long output hold-off.");
    if (board.owed_beats.size() != 0)
      board.report($sformatf("%0d expected beats never arrived", board.owed_beats.size()));
    if (board.errors == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule

>>> sim.f
rtl/core/eee_pkg.sv
rtl/core/eee_front.sv
rtl/core/eee_queue.sv
rtl/core/eee_back.sv
rtl/core/echo_escape_expander_core.sv
rtl/core/eee_checker.sv
bench/echo_escape_expander_core_test.sv
